[hdl/edist_pkg.sv]
// shared types and constants for the euclidean distance engine
// no dependencies; used by all edist_* modules and the top level
package edist_pkg;

  localparam int COORD_W   = 16;
  localparam int MAG_W     = 16;
  localparam int SQ_W      = 2 * MAG_W;
  localparam int SUM_W     = 40;
  localparam int ROOT_W    = SUM_W / 2;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int STEP_CNT_W = $clog2(SQRT_STEPS);
  localparam int REM_W     = ROOT_W + 2;

  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // default depth of the queue between accumulator and root unit
  localparam int QUEUE_DEPTH_DEF = 2;

  // finished sum of one vector pair, handed from front to back
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             ovf;
  } sum_entry_t;

  // queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

[hdl/euclidean_distance_engine.sv]
// Euclidean distance engine.
// Input channel (item_valid / item_stall): one coordinate pair per item,
// coord_a and coord_b signed Q8.8, last set on the final pair of a vector.
// Result channel (result_valid / result_stall): one item per vector pair,
// distance = floor(sqrt(sum of squared differences)) in unsigned Q12.8,
// saturated set when the 40-bit sum clipped at its maximum.
// Rate: the front takes one coordinate pair every cycle unless item_stall
// is high. The root unit resolves one result bit per cycle, so short vectors
// fill the sum queue and then item_stall rises until a slot frees.
// From the accepted last item to result_valid, when the root unit is free, a pair
// passes the magnitude and square pipe registers, accumulate and push, queue pop and 20 root steps.
// A stalled result holds in the output register while the front keeps
// accumulating the next vector pair behind it.
// Reset (rst, synchronous) clears the running sum, the queue, the pipe valid bits and
// the root unit state; no item or result is in flight afterwards.
// depends on edist_pkg, edist_front, edist_queue, edist_back
module euclidean_distance_engine #(
  parameter int QUEUE_DEPTH = edist_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  item_valid,
  output logic                                  item_stall,
  input  logic signed [edist_pkg::COORD_W-1:0]  coord_a,
  input  logic signed [edist_pkg::COORD_W-1:0]  coord_b,
  input  logic                                  last,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output logic [edist_pkg::ROOT_W-1:0]          distance,
  output logic                                  saturated
);

  edist_pkg::queue_status_t q_status;
  edist_pkg::sum_entry_t    push_entry;
  edist_pkg::sum_entry_t    pop_entry;
  logic                     push;
  logic                     pop;

  // accumulator front
  edist_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .coord_a    (coord_a),
    .coord_b    (coord_b),
    .last       (last),
    .q_status   (q_status),
    .push       (push),
    .push_entry (push_entry)
  );

  // finished sums waiting for the root unit
  edist_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .pop_entry  (pop_entry),
    .status     (q_status)
  );

  // square root back end
  edist_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_status     (q_status),
    .pop_entry    (pop_entry),
    .pop          (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .distance     (distance),
    .saturated    (saturated)
  );

endmodule

[hdl/edist_front.sv]
// front part: takes coordinate pairs, squares the difference, accumulates
// with saturation and pushes the finished sum on the last item
// depends on edist_pkg
module edist_front (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    item_valid,
  output logic                                    item_stall,
  input  logic signed [edist_pkg::COORD_W-1:0]    coord_a,
  input  logic signed [edist_pkg::COORD_W-1:0]    coord_b,
  input  logic                                    last,
  input  edist_pkg::queue_status_t                q_status,
  output logic                                    push,
  output edist_pkg::sum_entry_t                   push_entry
);

  logic                               adv;
  logic                               take;
  logic signed [edist_pkg::COORD_W:0] diff;
  logic [edist_pkg::COORD_W:0]        diff_abs;

  logic                               s1_valid;
  logic                               s1_last;
  logic [edist_pkg::MAG_W-1:0]        s1_mag;
  logic                               s2_valid;
  logic                               s2_last;
  logic [edist_pkg::SQ_W-1:0]         s2_sq;

  logic [edist_pkg::SUM_W-1:0]        sum;
  logic                               ovf;
  logic [edist_pkg::SUM_W:0]          total;
  logic                               hit;
  logic [edist_pkg::SUM_W-1:0]        sum_next;
  logic                               ovf_next;

  // hold the pipe only when a finished sum has nowhere to go
  assign adv        = !(s2_valid && s2_last && q_status.full);
  assign item_stall = !adv;
  assign take       = item_valid && adv;

  // magnitude of the difference, fits in 16 bits
  always_comb begin
    diff     = {coord_a[edist_pkg::COORD_W-1], coord_a} - {coord_b[edist_pkg::COORD_W-1], coord_b};
    diff_abs = diff[edist_pkg::COORD_W] ? (~diff + 1'b1) : diff;
  end

  // saturating accumulate of the square leaving stage two
  always_comb begin
    total    = {1'b0, sum} + {{(edist_pkg::SUM_W + 1 - edist_pkg::SQ_W){1'b0}}, s2_sq};
    hit      = total >= {1'b0, edist_pkg::SUM_MAX};
    sum_next = hit ? edist_pkg::SUM_MAX : total[edist_pkg::SUM_W-1:0];
    ovf_next = ovf || hit;
  end

  assign push           = adv && s2_valid && s2_last;
  assign push_entry.sum = sum_next;
  assign push_entry.ovf = ovf_next;

  // pipeline control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= take;
      s2_valid <= s1_valid;
    end
  end

  // pipeline payload
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_mag  <= diff_abs[edist_pkg::MAG_W-1:0];
      s1_last <= last;
      s2_sq   <= s1_mag * s1_mag;
      s2_last <= s1_last;
    end
  end

  // running sum, cleared after the last item of a vector pair
  always_ff @(posedge clk) begin
    if (rst) begin
      sum <= '0;
      ovf <= 1'b0;
    end else if (adv && s2_valid) begin
      if (s2_last) begin
        sum <= '0;
        ovf <= 1'b0;
      end else begin
        sum <= sum_next;
        ovf <= ovf_next;
      end
    end
  end

endmodule

[hdl/edist_queue.sv]
// short queue of finished sums between the accumulator and the root unit
// depends on edist_pkg
module edist_queue #(
  parameter int DEPTH = edist_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  input  edist_pkg::sum_entry_t      push_entry,
  input  logic                       pop,
  output edist_pkg::sum_entry_t      pop_entry,
  output edist_pkg::queue_status_t   status
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  edist_pkg::sum_entry_t entries [DEPTH];
  logic [PTR_W-1:0]      wr_ptr;
  logic [PTR_W-1:0]      rd_ptr;
  logic [CNT_W-1:0]      count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_entry    = entries[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[hdl/edist_back.sv]
// back part: bit-pair restoring square root of a 40-bit sum, one root bit
// per cycle, and the output register of the result channel
// depends on edist_pkg
module edist_back (
  input  logic                             clk,
  input  logic                             rst,
  input  edist_pkg::queue_status_t         q_status,
  input  edist_pkg::sum_entry_t            pop_entry,
  output logic                             pop,
  output logic                             result_valid,
  input  logic                             result_stall,
  output logic [edist_pkg::ROOT_W-1:0]     distance,
  output logic                             saturated
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } back_state_t;

  back_state_t                         state;
  back_state_t                         state_next;
  logic [edist_pkg::SUM_W-1:0]         rad;
  logic [edist_pkg::REM_W-1:0]         rem;
  logic [edist_pkg::ROOT_W-1:0]        root;
  logic [edist_pkg::STEP_CNT_W-1:0]    cnt;
  logic                                ovf;

  logic [edist_pkg::REM_W:0]           rem_sh;
  logic [edist_pkg::REM_W:0]           trial;
  logic                                fits;
  logic [edist_pkg::REM_W-1:0]         rem_next;
  logic [edist_pkg::ROOT_W-1:0]        root_next;

  // one restoring step: bring down two bits, try 4*root+1
  always_comb begin
    rem_sh    = {rem[edist_pkg::REM_W-2:0], rad[edist_pkg::SUM_W-1 -: 2]};
    trial     = {1'b0, root, 2'b01};
    fits      = rem_sh >= trial;
    rem_next  = fits ? edist_pkg::REM_W'(rem_sh - trial) : rem_sh[edist_pkg::REM_W-1:0];
    root_next = {root[edist_pkg::ROOT_W-2:0], fits};
  end

  // sequencer
  always_comb begin
    pop        = 1'b0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (!q_status.empty) begin
          pop        = 1'b1;
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!result_stall) begin
          if (!q_status.empty) begin
            pop        = 1'b1;
            state_next = ST_RUN;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  assign result_valid = (state == ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // root datapath
  always_ff @(posedge clk) begin
    if (pop) begin
      rad  <= pop_entry.sum;
      ovf  <= pop_entry.ovf;
      rem  <= '0;
      root <= '0;
      cnt  <= edist_pkg::STEP_CNT_W'(edist_pkg::SQRT_STEPS - 1);
    end else if (state == ST_RUN) begin
      rad  <= {rad[edist_pkg::SUM_W-3:0], 2'b00};
      rem  <= rem_next;
      root <= root_next;
      cnt  <= cnt - 1'b1;
    end
  end

  // output register, loaded on the final step
  always_ff @(posedge clk) begin
    if (state == ST_RUN && cnt == '0) begin
      distance  <= root_next;
      saturated <= ovf;
    end
  end

endmodule

[hdl/edist_checker.sv]
// port-level checks for the euclidean distance engine, bound to the top
// depends on edist_pkg
module edist_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  result_valid,
  input logic                                  result_stall,
  input logic [edist_pkg::ROOT_W-1:0]          distance,
  input logic                                  saturated
);

  // a result stays offered while stalled
  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");

  // a saturated sum always roots to the largest distance
  a_sat_root: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> distance == {edist_pkg::ROOT_W{1'b1}})
    else $error("saturated result with short distance");

  // nothing is offered right after reset
  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !result_valid)
    else $error("result offered after reset");

  // each result passes through the root steps, so results never come back to back
  a_result_spacing: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall |=> !result_valid)
    else $error("results closer than the root unit allows");

endmodule

bind euclidean_distance_engine edist_checker u_chk (.*);
